FILE: sv/srpc_pkg.sv
// Shared constants and types for the stepper ramp position controller.
package srpc_pkg;

    localparam int RAMP_STEPS_DEF = 100;

    // Divider geometry: 32-bit dividend, divisor up to 2*255.
    localparam int DQ_W  = 32;
    localparam int DIV_W = 9;
    localparam int CNT_W = 4;

    // Iterations per division minus one, two quotient bits per cycle.
    localparam logic [CNT_W-1:0] FULL_CYC = CNT_W'(DQ_W / 2 - 1);
    localparam logic [CNT_W-1:0] HALF_CYC = CNT_W'(DQ_W / 4 - 1);

    localparam logic [4:0] RAMP_START_PERIOD   = 5'd10;
    localparam logic [4:0] RAMP_REVERSE_PERIOD = 5'd20;
    localparam logic [7:0] START_SPEED_RST     = 8'd50;
    localparam logic [7:0] FAST_PERIOD_RST     = 8'd1;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    typedef struct packed {
        logic             start;
        logic             half;      // dividend holds 16 bits, left-aligned
        logic [DQ_W-1:0]  dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] rem;
        logic [DQ_W-1:0]  quo;
    } div_rsp_t;

endpackage

FILE: sv/srpc_divider.sv
// Shared restoring divider, two quotient bits per cycle.
module srpc_divider
(
    input  logic                clk,
    input  logic                rst_n,
    input  srpc_pkg::div_req_t  req,
    output srpc_pkg::div_rsp_t  rsp
);

    logic [srpc_pkg::DQ_W-1:0]  dq_reg;
    logic [srpc_pkg::DIV_W-1:0] rem_reg;
    logic [srpc_pkg::DIV_W-1:0] dvs_reg;
    logic [srpc_pkg::CNT_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [srpc_pkg::DIV_W:0]   a1;
    logic [srpc_pkg::DIV_W:0]   a2;
    logic [srpc_pkg::DIV_W-1:0] s1;
    logic [srpc_pkg::DIV_W-1:0] s2;
    logic                       q1;
    logic                       q2;

    always_comb
    begin
        a1 = {rem_reg, dq_reg[srpc_pkg::DQ_W-1]};
        q1 = (a1 >= {1'b0, dvs_reg});
        s1 = q1 ? srpc_pkg::DIV_W'(a1 - {1'b0, dvs_reg}) : srpc_pkg::DIV_W'(a1);
        a2 = {s1, dq_reg[srpc_pkg::DQ_W-2]};
        q2 = (a2 >= {1'b0, dvs_reg});
        s2 = q2 ? srpc_pkg::DIV_W'(a2 - {1'b0, dvs_reg}) : srpc_pkg::DIV_W'(a2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.half ? srpc_pkg::HALF_CYC : srpc_pkg::FULL_CYC;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dq_reg  <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[srpc_pkg::DQ_W-3:0], q1, q2};
            rem_reg <= s2;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;
    assign rsp.quo  = dq_reg;

endmodule

FILE: sv/stepper_ramp_position_controller.sv
// Top level: stepper channel with linear start ramp, sequenced over one divider.
// Tick item, accept to m_tvalid: three divider passes (ramp modulo, extra-period quotient,
//   step-period modulo), each with a start and a wait state, plus sequencer steps.
// Set item: ST_SET_A, ST_SET_B, ST_RESULT. One item at a time, s_tready only in idle.
// The result sits in an output register, so a new item may enter while it waits.
// Reset (rst_n, async, active low): state clears, ramp period 10, fast period 1, start_speed 50.
module stepper_ramp_position_controller
#(
    parameter int RAMP_STEPS = srpc_pkg::RAMP_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: start_speed
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // target_position[31:0], min_period[39:32], time_count[71:40]
    input  logic        s_tuser,  // operation: 0 tick, 1 set
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // step_level[0], direction[1], position[33:2],
                                  // move_done[34], zero[39:35]
);

    localparam int RC_W   = $clog2(RAMP_STEPS + 1);
    localparam int PROD_W = 8 + RC_W;
    localparam logic [RC_W-1:0] RAMP_MAX = RC_W'(RAMP_STEPS);

    // sequencer codes
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SET_A  = 4'd1;
    localparam logic [3:0] ST_SET_B  = 4'd2;
    localparam logic [3:0] ST_RSTART = 4'd3;
    localparam logic [3:0] ST_W_RAMP = 4'd4;
    localparam logic [3:0] ST_MUL    = 4'd5;
    localparam logic [3:0] ST_XSTART = 4'd6;
    localparam logic [3:0] ST_W_XTRA = 4'd7;
    localparam logic [3:0] ST_PSTART = 4'd8;
    localparam logic [3:0] ST_W_PER  = 4'd9;
    localparam logic [3:0] ST_RESULT = 4'd10;

    logic [3:0]  state_reg;
    logic [3:0]  state_next;

    // architectural state
    logic [7:0]      start_speed_reg;
    logic [31:0]     pos_reg;
    logic [31:0]     steps_reg;
    logic [31:0]     budget_reg;
    logic            dir_reg;
    logic            done_reg;
    logic            pulse_reg;
    logic [RC_W-1:0] rc_reg;
    logic [4:0]      rp_reg;
    logic [7:0]      fast_reg;

    // item latches and working values
    logic [31:0]     tgt_reg;
    logic [7:0]      minp_reg;
    logic [31:0]     t_reg;
    logic [31:0]     dist_reg;
    logic            want_reg;
    logic            same_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [srpc_pkg::DIV_W-1:0] period_reg;

    logic        mvalid_reg;
    logic [39:0] mdata_reg;

    srpc_pkg::div_req_t div_req;
    srpc_pkg::div_rsp_t div_rsp;

    logic        in_acc;
    logic        out_free;
    logic [32:0] sum;
    logic [8:0]  per_sum;
    logic [RC_W-1:0] rc_left;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    srpc_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // divider requests: ramp modulo, extra-period quotient, step-period modulo
    always_comb
    begin
        div_req          = '0;
        div_req.dividend = t_reg;
        div_req.divisor  = srpc_pkg::DIV_W'(rp_reg);
        unique case (state_reg)
            ST_RSTART:
            begin
                div_req.start = 1'b1;
            end
            ST_XSTART:
            begin
                div_req.start    = 1'b1;
                div_req.half     = 1'b1;
                div_req.dividend = {16'(prod_reg), 16'd0};
                div_req.divisor  = srpc_pkg::DIV_W'(RAMP_STEPS);
            end
            ST_PSTART:
            begin
                div_req.start   = 1'b1;
                div_req.divisor = period_reg;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (s_tuser == srpc_pkg::OP_SET) ? ST_SET_A : ST_RSTART;
                end
            end
            ST_SET_A:  state_next = ST_SET_B;
            ST_SET_B:  state_next = ST_RESULT;
            ST_RSTART: state_next = ST_W_RAMP;
            ST_W_RAMP: state_next = div_rsp.done ? ST_MUL : ST_W_RAMP;
            ST_MUL:    state_next = ST_XSTART;
            ST_XSTART: state_next = ST_W_XTRA;
            ST_W_XTRA: state_next = div_rsp.done ? ST_PSTART : ST_W_XTRA;
            ST_PSTART: state_next = ST_W_PER;
            ST_W_PER:  state_next = div_rsp.done ? ST_RESULT : ST_W_PER;
            ST_RESULT: state_next = out_free ? ST_IDLE : ST_RESULT;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign sum     = {1'b0, dist_reg} + {1'b0, steps_reg};
    assign rc_left = RAMP_MAX - rc_reg;
    // extra never exceeds start_speed, so 8 quotient bits suffice
    assign per_sum = {1'b0, fast_reg} + {1'b0, div_rsp.quo[7:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            start_speed_reg <= srpc_pkg::START_SPEED_RST;
            pos_reg         <= '0;
            steps_reg       <= '0;
            budget_reg      <= '0;
            dir_reg         <= 1'b0;
            done_reg        <= 1'b0;
            pulse_reg       <= 1'b0;
            rc_reg          <= '0;
            rp_reg          <= srpc_pkg::RAMP_START_PERIOD;
            fast_reg        <= srpc_pkg::FAST_PERIOD_RST;
            mvalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                start_speed_reg <= cfg_wr_data;
            end
            // load a new result, or drop the one just taken
            if ((state_reg == ST_RESULT) && out_free)
            begin
                mvalid_reg <= 1'b1;
            end
            else if (mvalid_reg && m_tready)
            begin
                mvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_SET_A:
                begin
                    fast_reg <= minp_reg;
                end
                ST_SET_B:
                begin
                    if (!same_reg)
                    begin
                        if (done_reg || (dir_reg != want_reg))
                        begin
                            // fresh move or reversal: restart the ramp
                            dir_reg    <= want_reg;
                            budget_reg <= dist_reg;
                            steps_reg  <= '0;
                            rc_reg     <= '0;
                            rp_reg     <= done_reg ? srpc_pkg::RAMP_START_PERIOD
                                                   : srpc_pkg::RAMP_REVERSE_PERIOD;
                        end
                        else
                        begin
                            // same direction: extend, saturate the budget
                            budget_reg <= sum[32] ? '1 : sum[31:0];
                        end
                    end
                end
                ST_W_RAMP:
                begin
                    if (div_rsp.done && (div_rsp.rem == '0) && (rc_reg < RAMP_MAX))
                    begin
                        rc_reg <= rc_reg + 1'b1;
                    end
                end
                ST_W_PER:
                begin
                    if (div_rsp.done && (div_rsp.rem == '0))
                    begin
                        if (steps_reg < budget_reg)
                        begin
                            done_reg  <= 1'b0;
                            pulse_reg <= ~pulse_reg;
                            steps_reg <= steps_reg + 1'b1;
                            pos_reg   <= dir_reg ? pos_reg - 1'b1 : pos_reg + 1'b1;
                        end
                        else
                        begin
                            done_reg <= 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            tgt_reg  <= s_tdata[31:0];
            minp_reg <= s_tdata[39:32];
            t_reg    <= s_tdata[71:40];
        end
        if (state_reg == ST_SET_A)
        begin
            same_reg <= (tgt_reg == pos_reg);
            want_reg <= !($signed(tgt_reg) > $signed(pos_reg));
            dist_reg <= ($signed(tgt_reg) > $signed(pos_reg)) ? tgt_reg - pos_reg
                                                              : pos_reg - tgt_reg;
        end
        if (state_reg == ST_MUL)
        begin
            // start_speed * remaining ramp steps; zero once the ramp is complete
            prod_reg <= PROD_W'(start_speed_reg) * PROD_W'(rc_left);
        end
        if ((state_reg == ST_W_XTRA) && div_rsp.done)
        begin
            period_reg <= (per_sum == '0) ? srpc_pkg::DIV_W'(1) : per_sum;
        end
        if ((state_reg == ST_RESULT) && out_free)
        begin
            mdata_reg <= {5'd0, done_reg, pos_reg, dir_reg, pulse_reg};
        end
    end

    // divider answers only while the sequencer waits for it
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_W_RAMP || state_reg == ST_W_XTRA ||
                          state_reg == ST_W_PER))
        else $error("divider done outside a wait state");

    a_ramp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rc_reg <= RAMP_MAX)
        else $error("ramp count beyond ramp length");

    a_ramp_period: assert property (@(posedge clk) disable iff (!rst_n)
        (rp_reg == srpc_pkg::RAMP_START_PERIOD) || (rp_reg == srpc_pkg::RAMP_REVERSE_PERIOD))
        else $error("ramp period corrupted");

    a_step_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_W_PER) |=> $stable(pos_reg) && $stable(pulse_reg))
        else $error("position moved outside step decision");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_tready)
        else $error("accepted a second item while busy");

endmodule

FILE: sim/stepper_ramp_position_controller_chk.sv
`timescale 1ns / 100ps
// Checker: predicts each stepper result from the accepted items and compares it field by field.
module stepper_ramp_position_controller_chk
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,   // target_position[31:0], min_period[39:32], time_count[71:40]
    input  logic        s_tuser,   // operation
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // step_level[0], direction[1], position[33:2], move_done[34]
    output int          pending,
    output int          fail_count
);

    localparam logic [31:0] RAMP_N = 32'(srpc_pkg::RAMP_STEPS_DEF);
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic        level;
        logic        minus;
        logic [31:0] pos;
        logic        done;
    } pins_t;

    // channel state as the block should hold it
    logic [7:0]  speed;
    logic [31:0] pos;
    logic [31:0] taken;
    logic [31:0] budget;
    logic        minus;
    logic        done;
    logic        level;
    logic [6:0]  ramp_cnt;
    logic [4:0]  ramp_per;
    logic [7:0]  fast_per;

    pins_t pin_forecast[$];
    int    accepted;
    int    checked;
    int    reported;

    assign pending = accepted - checked;

    function void restart_ramp(input logic [4:0] per);
        ramp_cnt = '0;
        ramp_per = per;
    endfunction

    function void retarget(input logic [31:0] tgt, input logic [7:0] minp);
        logic        want_minus;
        logic [31:0] distance;
        logic [32:0] sum;
        fast_per = minp;
        if (tgt != pos)
        begin
            want_minus = $signed(tgt) < $signed(pos);
            distance = want_minus ? pos - tgt : tgt - pos;
            if (done)
            begin
                minus  = want_minus;
                budget = distance;
                taken  = '0;
                restart_ramp(srpc_pkg::RAMP_START_PERIOD);
            end
            else if (minus == want_minus)
            begin
                // extend the running move, saturating the budget
                sum = {1'b0, distance} + {1'b0, taken};
                budget = sum[32] ? '1 : sum[31:0];
            end
            else
            begin
                minus  = want_minus;
                budget = distance;
                taken  = '0;
                restart_ramp(srpc_pkg::RAMP_REVERSE_PERIOD);
            end
        end
    endfunction

    function void step_on_tick(input logic [31:0] t);
        logic [31:0] extra;
        logic [31:0] period;
        extra = '0;
        if (ramp_per != '0 && (t % 32'(ramp_per)) == '0 && 32'(ramp_cnt) < RAMP_N)
            ramp_cnt = ramp_cnt + 7'd1;
        if (32'(ramp_cnt) < RAMP_N)
            extra = (32'(speed) * (RAMP_N - 32'(ramp_cnt))) / RAMP_N;
        period = 32'(fast_per) + extra;
        if (period == '0)
            period = 32'd1;
        if ((t % period) == '0)
        begin
            if (taken < budget)
            begin
                done  = 1'b0;
                level = ~level;
                taken = taken + 32'd1;
                pos   = minus ? pos - 32'd1 : pos + 32'd1;
            end
            else
            begin
                done = 1'b1;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        pins_t want;
        pins_t got;
        if (!rst_n)
        begin
            speed    = srpc_pkg::START_SPEED_RST;
            pos      = '0;
            taken    = '0;
            budget   = '0;
            minus    = 1'b0;
            done     = 1'b0;
            level    = 1'b0;
            ramp_cnt = '0;
            ramp_per = srpc_pkg::RAMP_START_PERIOD;
            fast_per = srpc_pkg::FAST_PERIOD_RST;
            reported = 0;
            pin_forecast.delete();
            accepted   <= 0;
            checked    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                speed = cfg_wr_data;
            if (m_tvalid && m_tready)
            begin
                got = '{m_tdata[0], m_tdata[1], m_tdata[33:2], m_tdata[34]};
                if (pin_forecast.size() == 0)
                begin
                    if (reported < REPORT_MAX)
                        $display("%0t: result with none expected: step=%0b dir=%0b pos=%0d done=%0b",
                                 $time, got.level, got.minus, $signed(got.pos), got.done);
                    reported   = reported + 1;
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = pin_forecast.pop_front();
                    checked <= checked + 1;
                    if (got !== want || m_tdata[39:35] !== '0)
                    begin
                        if (reported < REPORT_MAX)
                        begin
                            $write("%0t: mismatch: want step=%0b dir=%0b pos=%0d done=%0b,",
                                   $time, want.level, want.minus, $signed(want.pos), want.done);
                            $display(" got step=%0b dir=%0b pos=%0d done=%0b pad=%h",
                                     got.level, got.minus, $signed(got.pos), got.done,
                                     m_tdata[39:35]);
                        end
                        reported   = reported + 1;
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == srpc_pkg::OP_SET)
                    retarget(s_tdata[31:0], s_tdata[39:32]);
                else
                    step_on_tick(s_tdata[71:40]);
                pin_forecast.push_back('{level, minus, pos, done});
                accepted <= accepted + 1;
            end
        end
    end

endmodule

FILE: sim/stepper_ramp_position_controller_test.sv
`timescale 1ns / 100ps
// Testbench top: drives items and start_speed into the stepper controller and reports the verdict.
module stepper_ramp_position_controller_test;

    localparam int RUN_LIMIT    = 1_000_000;  // cycles
    localparam int DRAIN_CYCLES = 60;         // a bit more than one tick item's latency
    localparam int DIRECTED_N   = 25;
    localparam int PHASE_ITEMS  = 205;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata     = '0;  // target_position[31:0], min_period[39:32], time_count[71:40]
    logic        s_tuser     = 1'b0;  // operation
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [39:0] m_tdata;           // step_level[0], direction[1], position[33:2], move_done[34]

    int          pending;
    int          fail_count;
    int          cyc        = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    int          rdy_mode   = 0;
    int          rdy_hold   = 0;
    logic [31:0] t_clock    = '0;   // free-running time the tick items mostly follow
    logic [31:0] last_pos   = '0;   // position from the latest result taken

    always #6 clk = ~clk;

    stepper_ramp_position_controller dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    stepper_ramp_position_controller_chk chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .pending     (pending),
        .fail_count  (fail_count)
    );

    always @(posedge clk)
        cyc <= cyc + 1;

    // Result side back-pressure. A new mode is picked each time the random hold runs out:
    //   0 always ready, 1 ready 3/4 of the time at random,
    //   2 fixed pattern stalling 18/32 of the time, 3 mostly stalled.
    always @(posedge clk)
    begin
        if (rdy_hold == 0)
        begin
            rdy_mode <= $urandom_range(0, 3);
            rdy_hold <= $urandom_range(60, 400);
        end
        else
        begin
            rdy_hold <= rdy_hold - 1;
        end
        case (rdy_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ((cyc % 32) >= 18);
            default: m_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // keep the last reported position so targets can be placed near it
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            last_pos <= m_tdata[33:2];
    end

    // watchdog
    initial
    begin
        while (cyc < RUN_LIMIT)
            @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    // Offer one item and hold it until the block takes it. Items go out in
    // bursts; between bursts the sender idles a random number of cycles, so
    // gaps land anywhere in the block's multi-cycle tick sequence.
    task automatic push_item(input logic op, input logic [31:0] tgt, input logic [7:0] minp,
                             input logic [31:0] t);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {t, minp, tgt};
        do
            @(posedge clk);
        while (!s_tready);
        burst_left = burst_left - 1;
        items_sent = items_sent + 1;
    endtask

    // unused fields of an item carry random bits
    task automatic set_target(input logic [31:0] tgt, input logic [7:0] minp);
        push_item(srpc_pkg::OP_SET, tgt, minp, $urandom());
    endtask

    task automatic tick_at(input logic [31:0] t);
        push_item(srpc_pkg::OP_TICK, $urandom(), 8'($urandom()), t);
    endtask

    // stop sending and wait until every expected result has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // start_speed only changes while the block is idle
    task automatic write_speed(input logic [7:0] v);
        drain();
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Tick time: mostly an advancing count, sometimes zero (a multiple of
    // every period), a large multiple of 1..10, or any 32-bit value.
    function automatic logic [31:0] next_time();
        int r;
        r = $urandom_range(0, 19);
        if (r < 13)
        begin
            t_clock = t_clock + 32'($urandom_range(1, 3));
            return t_clock;
        end
        else if (r < 15)
            return '0;
        else if (r < 17)
            return 32'($urandom_range(1, 2000)) * 32'd2520;
        else if (r < 19)
            return $urandom();
        return t_clock;
    endfunction

    // short periods keep steps frequent; now and then any 8-bit value, zero included
    function automatic logic [7:0] pick_period();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(1, 6));
    endfunction

    function automatic logic [31:0] near_target();
        return last_pos + 32'($urandom_range(0, 60)) - 32'd30;
    endfunction

    // Random part: mostly whole moves (a target close to the current position
    // followed by a run of ticks), plus back-to-back targets that extend or
    // reverse a running move, and noise with full-range fields.
    task automatic random_moves(input int goal);
        int kind;
        while (items_sent < goal)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                set_target(near_target(), pick_period());
                repeat ($urandom_range(2, 30)) tick_at(next_time());
            end
            else if (kind == 7)
            begin
                repeat ($urandom_range(1, 8)) tick_at($urandom());
            end
            else if (kind == 8)
            begin
                set_target($urandom(), 8'($urandom()));
                repeat ($urandom_range(1, 5)) tick_at(next_time());
            end
            else
            begin
                set_target(near_target(), pick_period());
                set_target(near_target(), pick_period());
                repeat ($urandom_range(2, 20)) tick_at(next_time());
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, ramp extra disabled so periods are exactly min_period.
        write_speed(8'd0);
        tick_at(32'hFFFF_FFFF);            // empty budget: move reports done
        tick_at(32'd0);
        set_target(32'd3, 8'd1);           // new move while done, plus direction
        tick_at(32'd1);
        tick_at(32'd2);
        set_target(32'd10, 8'd2);          // same direction while moving: extend
        tick_at(32'd4);
        tick_at(32'd5);                    // off the period, no step
        set_target(-32'sd5, 8'd0);         // reverse while moving, zero min period
        tick_at(32'd7);                    // zero period falls back to one
        tick_at(32'd0);
        set_target(32'h8000_0000, 8'd255); // most negative target, same direction
        tick_at(32'd255);
        set_target(32'h7FFF_FFFF, 8'd1);   // most positive target: reverse
        tick_at(32'd0);
        drain();                           // hold off until every result is in
        set_target(last_pos, 8'd3);        // present position while moving
        tick_at(32'd3);
        drain();
        set_target(last_pos + 32'd2, 8'd1); // shrink the move so it finishes
        repeat (4) tick_at(32'd0);
        drain();
        set_target(last_pos, 8'd9);        // present position while done
        set_target(last_pos - 32'd1, 8'd1); // new move while done, minus direction
        tick_at(32'd0);

        // Random phases, each under its own start_speed, extremes included.
        for (int ph = 1; ph <= 5; ph++)
        begin
            case (ph)
                1:       write_speed(8'd255);
                2:       write_speed(srpc_pkg::START_SPEED_RST);
                3:       write_speed(8'd1);
                default: write_speed(8'($urandom_range(2, 254)));
            endcase
            random_moves(DIRECTED_N + ph * PHASE_ITEMS);
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
